/* design/hds_pkg.sv */
// ---------------------------------------------------------------------------
// hds_pkg: shared types and constants for the heat diffusion stencil
// Widths of the cell, gain and partial results, register codes and resets.
// ---------------------------------------------------------------------------
package hds_pkg;

  localparam int MaxSide  = 32;
  localparam int ColW     = (MaxSide > 1) ? $clog2(MaxSide) : 1;
  localparam int RowW     = $clog2(MaxSide + 2);   // rows run on to side + 1 in the flush
  localparam int SideW    = 6;
  localparam int TempW    = 16;
  localparam int GainW    = 16;                    // Q0.16
  localparam int CntW     = 4;                     // up to 8 neighbors
  localparam int SumW     = TempW + 3;
  localparam int DiffW    = SumW + 1;
  localparam int ProdW    = DiffW + GainW + 1;
  localparam int TotW     = ProdW + 1;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 16;

  localparam logic [TotW-1:0] RoundHalf = TotW'(1) << (GainW - 1);

  // register codes
  localparam logic [CfgIdxW-1:0] CfgGridSide = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgGain     = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgTol      = 2'd2;

  // reset values; the gain is the fixed-point form of the default physics
  localparam logic [SideW-1:0] SideRst = SideW'(MaxSide);
  localparam logic [GainW-1:0] GainRst = 16'd26651;
  localparam logic [TempW-1:0] TolRst  = 16'd16;

  typedef logic [TempW-1:0] temp_t;

  // one grid column of the 3x3 window: row above, middle row, row below
  typedef struct packed {
    temp_t up;
    temp_t mid;
    temp_t dn;
  } col_t;

  // per-item control that travels down the pipe
  typedef struct packed {
    logic emit;        // item completes a window, a result is due
    logic at_top;
    logic at_bottom;
    logic at_left;
    logic at_right;
    logic frame_last;
    logic at_eq;
  } tag_t;

endpackage

/* design/hds_in_if.sv */
// ---------------------------------------------------------------------------
// hds_in_if: input item channel
// Valid/ready stream of old cell temperatures in raster order.
// ---------------------------------------------------------------------------
interface hds_in_if;
  import hds_pkg::*;

  logic  valid;
  logic  ready;
  temp_t cell_temperature;

  modport source (output valid, output cell_temperature, input ready);
  modport sink   (input valid, input cell_temperature, output ready);
endinterface

/* design/hds_out_if.sv */
// ---------------------------------------------------------------------------
// hds_out_if: result item channel
// Valid/ready stream of updated cells with frame end and equilibrium flags.
// ---------------------------------------------------------------------------
interface hds_out_if;
  import hds_pkg::*;

  logic  valid;
  logic  ready;
  temp_t new_temperature;
  logic  frame_last;
  logic  at_equilibrium;

  modport source (output valid, output new_temperature, output frame_last,
                  output at_equilibrium, input ready);
  modport sink   (input valid, input new_temperature, input frame_last,
                  input at_equilibrium, output ready);
endinterface

/* design/hds_line_buf.sv */
// ---------------------------------------------------------------------------
// hds_line_buf: one grid row of storage
// Read-first single port RAM, registered read data, one access per enable.
// ---------------------------------------------------------------------------
module hds_line_buf (
  input  logic                     clk,
  input  logic                     en,
  input  logic [hds_pkg::ColW-1:0] addr,
  input  hds_pkg::temp_t           wdata,
  output hds_pkg::temp_t           rdata
);
  import hds_pkg::*;

  temp_t mem [MaxSide];
  temp_t rdata_r;

  always_ff @(posedge clk) begin
    if (en) begin
      rdata_r    <= mem[addr];
      mem[addr]  <= wdata;
    end
  end

  assign rdata = rdata_r;

endmodule

/* design/hds_frame_ctrl.sv */
// ---------------------------------------------------------------------------
// hds_frame_ctrl: raster position, flush sequencing and equilibrium check
// Tags each item entering the pipe (stage A) and generates flush items.
// ---------------------------------------------------------------------------
module hds_frame_ctrl (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      restart,
  input  logic [hds_pkg::SideW-1:0] side,
  input  hds_pkg::temp_t            tol,
  input  logic                      issue,
  input  hds_pkg::temp_t            cell_in,
  output logic                      flush,
  output logic [hds_pkg::ColW-1:0]  col,
  output hds_pkg::tag_t             issue_tag,
  output hds_pkg::temp_t            a_cell,
  output logic [hds_pkg::ColW-1:0]  a_col,
  output hds_pkg::tag_t             a_tag
);
  import hds_pkg::*;

  logic [RowW-1:0]  row_r, row_nxt;
  logic [ColW-1:0]  col_r, col_nxt;
  logic [ColW-1:0]  prow_r, prow_nxt;   // position of the next result
  logic [ColW-1:0]  pcol_r, pcol_nxt;
  logic             flush_r, flush_nxt;
  temp_t            ref_r, ref_nxt;
  logic             eq_r, eq_nxt;

  temp_t            a_cell_r;
  logic [ColW-1:0]  a_col_r;
  tag_t             a_tag_r;

  logic [SideW-1:0] side_m1;
  logic             col_end, row_end, emit, p_end_col, p_end_row, first;
  temp_t            ref_use, dev;

  always_comb begin
    side_m1   = side - SideW'(1);
    col_end   = (SideW'(col_r) == side_m1);
    row_end   = (row_r == RowW'(side_m1));
    // linear index >= side + 1
    emit      = (row_r >= RowW'(2)) || ((row_r == RowW'(1)) && (col_r != '0));
    p_end_col = (SideW'(pcol_r) == side_m1);
    p_end_row = (SideW'(prow_r) == side_m1);

    issue_tag = '{emit:       emit,
                  at_top:     (prow_r == '0),
                  at_bottom:  p_end_row,
                  at_left:    (pcol_r == '0),
                  at_right:   p_end_col,
                  frame_last: p_end_row && p_end_col,
                  at_eq:      eq_r && p_end_row && p_end_col};

    first   = !flush_r && (row_r == '0) && (col_r == '0);
    ref_use = first ? cell_in : ref_r;
    dev     = (cell_in > ref_use) ? (cell_in - ref_use) : (ref_use - cell_in);

    row_nxt   = row_r;
    col_nxt   = col_r;
    prow_nxt  = prow_r;
    pcol_nxt  = pcol_r;
    flush_nxt = flush_r;
    ref_nxt   = ref_r;
    eq_nxt    = eq_r;

    if (col_end) begin
      col_nxt = '0;
      row_nxt = row_r + RowW'(1);
    end else begin
      col_nxt = col_r + ColW'(1);
    end

    if (!flush_r) begin
      ref_nxt = ref_use;
      eq_nxt  = (first || eq_r) && (dev <= tol);
      if (row_end && col_end) begin
        flush_nxt = 1'b1;
      end
    end

    if (emit) begin
      if (p_end_col) begin
        pcol_nxt = '0;
        prow_nxt = prow_r + ColW'(1);
      end else begin
        pcol_nxt = pcol_r + ColW'(1);
      end
      // last result of the frame issued: frame done
      if (p_end_row && p_end_col) begin
        row_nxt   = '0;
        col_nxt   = '0;
        prow_nxt  = '0;
        pcol_nxt  = '0;
        flush_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      row_r   <= '0;
      col_r   <= '0;
      prow_r  <= '0;
      pcol_r  <= '0;
      flush_r <= 1'b0;
      ref_r   <= '0;
      eq_r    <= 1'b1;
    end else if (issue) begin
      row_r   <= row_nxt;
      col_r   <= col_nxt;
      prow_r  <= prow_nxt;
      pcol_r  <= pcol_nxt;
      flush_r <= flush_nxt;
      ref_r   <= ref_nxt;
      eq_r    <= eq_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      a_cell_r <= cell_in;
      a_col_r  <= col_r;
      a_tag_r  <= issue_tag;
    end
  end

  assign flush  = flush_r;
  assign col    = col_r;
  assign a_cell = a_cell_r;
  assign a_col  = a_col_r;
  assign a_tag  = a_tag_r;

endmodule

/* design/hds_window.sv */
// ---------------------------------------------------------------------------
// hds_window: 3x3 window (stage C) and masked neighbor sum (stage D)
// Columns shift in one per item; out-of-grid neighbors are dropped.
// ---------------------------------------------------------------------------
module hds_window (
  input  logic                      clk,
  input  logic                      ld_c,
  input  hds_pkg::col_t             col_in,
  input  hds_pkg::tag_t             tag_in,
  input  logic                      ld_d,
  output logic                      c_emit,
  output logic [hds_pkg::SumW-1:0]  d_sum,
  output logic [hds_pkg::CntW-1:0]  d_cnt,
  output hds_pkg::temp_t            d_cell,
  output hds_pkg::tag_t             d_tag
);
  import hds_pkg::*;

  col_t            w0_r, w1_r, w2_r;   // left, center, right columns
  tag_t            c_tag_r;

  logic [SumW-1:0] d_sum_r;
  logic [CntW-1:0] d_cnt_r;
  temp_t           d_cell_r;
  tag_t            d_tag_r;

  temp_t           nb [8];
  logic [7:0]      use_nb;
  logic [SumW-1:0] sum_c;

  always_ff @(posedge clk) begin
    if (ld_c) begin
      w0_r    <= w1_r;
      w1_r    <= w2_r;
      w2_r    <= col_in;
      c_tag_r <= tag_in;
    end
  end

  always_comb begin
    nb[0] = w0_r.up;   use_nb[0] = !c_tag_r.at_top    && !c_tag_r.at_left;
    nb[1] = w0_r.mid;  use_nb[1] = !c_tag_r.at_left;
    nb[2] = w0_r.dn;   use_nb[2] = !c_tag_r.at_bottom && !c_tag_r.at_left;
    nb[3] = w1_r.up;   use_nb[3] = !c_tag_r.at_top;
    nb[4] = w1_r.dn;   use_nb[4] = !c_tag_r.at_bottom;
    nb[5] = w2_r.up;   use_nb[5] = !c_tag_r.at_top    && !c_tag_r.at_right;
    nb[6] = w2_r.mid;  use_nb[6] = !c_tag_r.at_right;
    nb[7] = w2_r.dn;   use_nb[7] = !c_tag_r.at_bottom && !c_tag_r.at_right;

    sum_c = '0;
    for (int i = 0; i < 8; i++) begin
      if (use_nb[i]) begin
        sum_c = sum_c + SumW'(nb[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld_d) begin
      d_sum_r  <= sum_c;
      d_cnt_r  <= CntW'($countones(use_nb));
      d_cell_r <= w1_r.mid;
      d_tag_r  <= c_tag_r;
    end
  end

  assign c_emit = c_tag_r.emit;
  assign d_sum  = d_sum_r;
  assign d_cnt  = d_cnt_r;
  assign d_cell = d_cell_r;
  assign d_tag  = d_tag_r;

endmodule

/* design/hds_arith.sv */
// ---------------------------------------------------------------------------
// hds_arith: Laplacian, gain multiply, round and saturate
// Stage E: sum - count*t. Stage F: times gain. Stage O: add t, round, clamp.
// ---------------------------------------------------------------------------
module hds_arith (
  input  logic                      clk,
  input  logic [hds_pkg::GainW-1:0] gain,
  input  logic                      ld_e,
  input  logic                      ld_f,
  input  logic                      ld_o,
  input  logic [hds_pkg::SumW-1:0]  d_sum,
  input  logic [hds_pkg::CntW-1:0]  d_cnt,
  input  hds_pkg::temp_t            d_cell,
  input  hds_pkg::tag_t             d_tag,
  output hds_pkg::temp_t            o_temp,
  output logic                      o_last,
  output logic                      o_eq
);
  import hds_pkg::*;

  logic        [SumW-1:0]  cnt_t;
  logic signed [DiffW-1:0] diff_c;
  logic signed [DiffW-1:0] e_diff_r;
  temp_t                   e_cell_r;
  tag_t                    e_tag_r;

  logic signed [GainW:0]   gain_s;
  logic signed [ProdW-1:0] prod_c;
  logic signed [ProdW-1:0] f_prod_r;
  temp_t                   f_cell_r;
  tag_t                    f_tag_r;

  logic signed [TotW-1:0]  total_c;
  temp_t                   sat_c;
  temp_t                   o_temp_r;
  logic                    o_last_r;
  logic                    o_eq_r;

  // stage E
  always_comb begin
    cnt_t  = SumW'(d_cnt) * SumW'(d_cell);
    diff_c = $signed({1'b0, d_sum}) - $signed({1'b0, cnt_t});
  end

  always_ff @(posedge clk) begin
    if (ld_e) begin
      e_diff_r <= diff_c;
      e_cell_r <= d_cell;
      e_tag_r  <= d_tag;
    end
  end

  // stage F
  always_comb begin
    gain_s = $signed({1'b0, gain});
    prod_c = e_diff_r * gain_s;
  end

  always_ff @(posedge clk) begin
    if (ld_f) begin
      f_prod_r <= prod_c;
      f_cell_r <= e_cell_r;
      f_tag_r  <= e_tag_r;
    end
  end

  // stage O: t in Q.16 plus the update, round half up, clamp to 16 bits
  always_comb begin
    total_c = $signed({{(TotW - TempW - GainW){1'b0}}, f_cell_r, {GainW{1'b0}}})
            + TotW'(f_prod_r) + $signed(RoundHalf);
    if (total_c[TotW-1]) begin
      sat_c = '0;
    end else if (|total_c[TotW-2:TempW+GainW]) begin
      sat_c = '1;
    end else begin
      sat_c = total_c[TempW+GainW-1:GainW];
    end
  end

  always_ff @(posedge clk) begin
    if (ld_o) begin
      o_temp_r <= sat_c;
      o_last_r <= f_tag_r.frame_last;
      o_eq_r   <= f_tag_r.at_eq;
    end
  end

  assign o_temp = o_temp_r;
  assign o_last = o_last_r;
  assign o_eq   = o_eq_r;

endmodule

/* design/heat_diffusion_stencil_core.sv */
// ---------------------------------------------------------------------------
// heat_diffusion_stencil_core: one explicit heat diffusion step, 3x3 stencil
// Streams a square grid in raster order, emits updated cells one row plus
// one cell behind, flushes the tail of the frame after its last cell.
// ---------------------------------------------------------------------------
//
// Port     Way  Flow control        Carries
// in_if    in   valid / ready       cell_temperature, Q12.4 K, raster order
// out_if   out  valid / ready       new_temperature, frame_last, at_equilibrium
// cfg_*    in   cfg_we, no stall    cfg_idx selects grid side / gain / tolerance
//
// One item per cycle in steady state while out_if is not stalled. Seven register stages from an item
// entering to the result it completes appearing on out_if.
// After a frame's last cell, side + 1 flush items are generated internally,
// one per cycle while stage A can take them; in_if.ready stays low until all are issued.
// Synchronous active-low reset clears control and valids; line buffers hold
// garbage until written, which is never read unmasked. No clearing pass.
// Each stage advances when the next is empty or moving, so bubbles close up
// and a stall on out_if holds every item in place.
//
// Pipe: A frame position + row-above line buffer read
//       B row-two-above line buffer read
//       C 3x3 window, D masked neighbor sum, E Laplacian,
//       F gain multiply, O round / saturate / output register
// ---------------------------------------------------------------------------
module heat_diffusion_stencil_core (
  input  logic                        clk,
  input  logic                        rst_n,
  hds_in_if.sink                      in_if,
  hds_out_if.source                   out_if,
  input  logic                        cfg_we,
  input  logic [hds_pkg::CfgIdxW-1:0] cfg_idx,
  input  logic [hds_pkg::CfgDataW-1:0] cfg_wdata
);
  import hds_pkg::*;

  // configuration
  logic [SideW-1:0] side_r;
  logic [GainW-1:0] gain_r;
  temp_t            tol_r;
  logic [SideW-1:0] side_wr, side_wr_eff;
  logic             cfg_restart;

  // pipe control
  logic v_a_r, v_b_r, v_c_r, v_d_r, v_e_r, v_f_r, v_o_r;
  logic en_a, en_b, en_c, en_d, en_e, en_f, en_o;
  logic issue, ld_b, ld_c, ld_d, ld_e, ld_f, ld_o;

  // stage A
  logic             flush;
  logic [ColW-1:0]  col;
  tag_t             issue_tag;
  temp_t            issue_cell;
  temp_t            a_cell;
  logic [ColW-1:0]  a_col;
  tag_t             a_tag;
  temp_t            l1_rdata;

  // stage B
  temp_t            l2_rdata;
  temp_t            b_mid_r, b_dn_r;
  tag_t             b_tag_r;
  col_t             b_col;

  // stages C..O
  logic             c_emit;
  logic [SumW-1:0]  d_sum;
  logic [CntW-1:0]  d_cnt;
  temp_t            d_cell;
  tag_t             d_tag;

  // ------------------------------------------------------------------
  // Configuration registers. Grid side is clamped to 1..MaxSide on write
  // and restarts the frame.
  // ------------------------------------------------------------------
  always_comb begin
    side_wr = cfg_wdata[SideW-1:0];
    if (side_wr == '0) begin
      side_wr_eff = SideW'(1);
    end else if (side_wr > SideW'(MaxSide)) begin
      side_wr_eff = SideW'(MaxSide);
    end else begin
      side_wr_eff = side_wr;
    end
    cfg_restart = cfg_we && (cfg_idx == CfgGridSide);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_r <= SideRst;
      gain_r <= GainRst;
      tol_r  <= TolRst;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CfgGridSide: side_r <= side_wr_eff;
        CfgGain:     gain_r <= cfg_wdata[GainW-1:0];
        CfgTol:      tol_r  <= cfg_wdata[TempW-1:0];
        default: ;
      endcase
    end
  end

  // ------------------------------------------------------------------
  // Stage enables: a stage loads when it is empty or its item moves on.
  // ------------------------------------------------------------------
  always_comb begin
    en_o = !v_o_r || out_if.ready;
    en_f = !v_f_r || en_o;
    en_e = !v_e_r || en_f;
    en_d = !v_d_r || en_e;
    en_c = !v_c_r || en_d;
    en_b = !v_b_r || en_c;
    en_a = !v_a_r || en_b;

    // flush items take the input slot while the frame tail drains
    issue = en_a && (flush || in_if.valid);
    ld_b  = en_b && v_a_r;
    ld_c  = en_c && v_b_r;
    ld_d  = en_d && v_c_r && c_emit;
    ld_e  = en_e && v_d_r;
    ld_f  = en_f && v_e_r;
    ld_o  = en_o && v_f_r;

    issue_cell = flush ? '0 : in_if.cell_temperature;
  end

  assign in_if.ready = en_a && !flush;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_a_r <= 1'b0;
      v_b_r <= 1'b0;
      v_c_r <= 1'b0;
      v_d_r <= 1'b0;
      v_e_r <= 1'b0;
      v_f_r <= 1'b0;
      v_o_r <= 1'b0;
    end else begin
      if (en_a) v_a_r <= issue;
      if (en_b) v_b_r <= v_a_r;
      if (en_c) v_c_r <= v_b_r;
      if (en_d) v_d_r <= v_c_r && c_emit;   // items with no result end here
      if (en_e) v_e_r <= v_d_r;
      if (en_f) v_f_r <= v_e_r;
      if (en_o) v_o_r <= v_f_r;
    end
  end

  // ------------------------------------------------------------------
  // Stage A: position tracking, equilibrium, row above from line 1
  // ------------------------------------------------------------------
  hds_frame_ctrl u_frame_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .restart   (cfg_restart),
    .side      (side_r),
    .tol       (tol_r),
    .issue     (issue),
    .cell_in   (issue_cell),
    .flush     (flush),
    .col       (col),
    .issue_tag (issue_tag),
    .a_cell    (a_cell),
    .a_col     (a_col),
    .a_tag     (a_tag)
  );

  hds_line_buf u_line1 (
    .clk   (clk),
    .en    (issue),
    .addr  (col),
    .wdata (issue_cell),
    .rdata (l1_rdata)
  );

  // ------------------------------------------------------------------
  // Stage B: line 2 delays line 1 by one more row
  // ------------------------------------------------------------------
  hds_line_buf u_line2 (
    .clk   (clk),
    .en    (ld_b),
    .addr  (a_col),
    .wdata (l1_rdata),
    .rdata (l2_rdata)
  );

  always_ff @(posedge clk) begin
    if (ld_b) begin
      b_mid_r <= l1_rdata;
      b_dn_r  <= a_cell;
      b_tag_r <= a_tag;
    end
  end

  assign b_col = '{up: l2_rdata, mid: b_mid_r, dn: b_dn_r};

  // ------------------------------------------------------------------
  // Stages C, D: window and neighbor sum
  // ------------------------------------------------------------------
  hds_window u_window (
    .clk    (clk),
    .ld_c   (ld_c),
    .col_in (b_col),
    .tag_in (b_tag_r),
    .ld_d   (ld_d),
    .c_emit (c_emit),
    .d_sum  (d_sum),
    .d_cnt  (d_cnt),
    .d_cell (d_cell),
    .d_tag  (d_tag)
  );

  // ------------------------------------------------------------------
  // Stages E, F, O: arithmetic and output register
  // ------------------------------------------------------------------
  hds_arith u_arith (
    .clk    (clk),
    .gain   (gain_r),
    .ld_e   (ld_e),
    .ld_f   (ld_f),
    .ld_o   (ld_o),
    .d_sum  (d_sum),
    .d_cnt  (d_cnt),
    .d_cell (d_cell),
    .d_tag  (d_tag),
    .o_temp (out_if.new_temperature),
    .o_last (out_if.frame_last),
    .o_eq   (out_if.at_equilibrium)
  );

  assign out_if.valid = v_o_r;

  // ------------------------------------------------------------------
  // Assertions
  // ------------------------------------------------------------------
  // equilibrium is only reported on the frame's last result
  a_eq_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && out_if.at_equilibrium |-> out_if.frame_last)
    else $error("at_equilibrium set on a result that is not frame_last");

  // issuing the frame's last result ends the flush
  a_flush_ends: assert property (@(posedge clk) disable iff (!rst_n)
    flush && issue && issue_tag.emit && issue_tag.frame_last |=> !flush)
    else $error("flush did not end after the frame's last result");

  // while flushing, every open slot of stage A is filled by a flush item
  a_flush_feeds: assert property (@(posedge clk) disable iff (!rst_n)
    flush && en_a && !cfg_restart |=> v_a_r)
    else $error("flush left a bubble in stage A");

endmodule

/* dv/tb.sv */
// ---------------------------------------------------------------------------
// tb: regression bench for heat_diffusion_stencil_core
// Streams grids of old cell temperatures through the stencil core, predicts
// every updated cell with a software copy of the diffusion step, and checks
// each result item in order. Grid side, gain and tolerance change between
// phases, with random idling on both channels and one long output hold-off.
// ---------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import hds_pkg::*;

  // spare register index, the core ignores writes to it
  localparam logic [CfgIdxW-1:0] CfgSpare = 2'd3;

  // drain wait once nothing is expected, to cover the pipe and a full flush
  localparam int DrainCycles = 64;
  // target for the random part, counted in input items
  localparam int RandomItems = 470;

  typedef enum {FillRandom, FillNearFlat, FillExtreme} fill_t;

  typedef struct {
    temp_t temp;
    bit    last;
    bit    eq;
  } new_cell_t;

  logic clk;
  logic rst_n;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_wdata;

  hds_in_if  in_ch ();
  hds_out_if out_ch ();

  heat_diffusion_stencil_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_ch),
    .out_if    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  // -------------------------------------------------------------------------
  // Shadow of the block: registers, line stores and frame position
  // -------------------------------------------------------------------------
  logic [SideW-1:0] side_reg;
  logic [GainW-1:0] gain_reg;
  logic [TempW-1:0] tol_reg;
  temp_t            line_rows [4][MaxSide];
  int unsigned      row_pos;
  int unsigned      col_pos;
  temp_t            base_temp;   // first cell of the frame
  bit               eq_run;      // every cell so far within tolerance

  temp_t     old_cell_q [$];     // items waiting for the driver
  new_cell_t new_cell_q [$];     // updated cells still to come out

  int cells_queued;
  int cells_taken;
  int results_seen;
  int frames_seen;
  int eq_frames;
  int errors;
  int phases;

  bit tx_idle;                   // sender may insert gaps
  bit rx_idle;                   // receiver may insert stalls
  int tx_gap;
  int rx_gap;
  logic hold_go;                 // starts the long receiver hold-off
  int   hold_left;

  function automatic int unsigned side_eff();
    if (side_reg == 0) return 1;
    if (side_reg > MaxSide) return MaxSide;
    return int'(side_reg);
  endfunction

  function automatic void restart_frame();
    row_pos   = 0;
    col_pos   = 0;
    base_temp = '0;
    eq_run    = 1'b1;
  endfunction

  // New value of one cell from its in-grid neighbors; corners see 3 of them,
  // other edge cells 5, a one-cell grid none.
  function automatic temp_t diffuse_cell(int unsigned r, int unsigned c,
                                         int unsigned side);
    longint t;
    longint nb_sum;
    longint cnt;
    longint total;
    longint nr;
    longint nc;
    longint q;
    t      = line_rows[r % 4][c];
    nb_sum = 0;
    cnt    = 0;
    for (int dr = -1; dr <= 1; dr++) begin
      for (int dc = -1; dc <= 1; dc++) begin
        nr = longint'(r) + dr;
        nc = longint'(c) + dc;
        if (dr == 0 && dc == 0) continue;
        if (nr < 0 || nc < 0 || nr >= side || nc >= side) continue;
        nb_sum += line_rows[nr % 4][nc];
        cnt++;
      end
    end
    total = t * 65536 + (nb_sum - cnt * t) * longint'(gain_reg) + 32768;
    if (total < 0) return '0;
    q = total >>> 16;
    if (q > 65535) q = 65535;
    return temp_t'(q);
  endfunction

  // One accepted item: store it, track equilibrium, queue the cells it
  // completes. The frame's last cell also releases all cells still held.
  function automatic void step_grid(temp_t t);
    int unsigned side;
    int unsigned r;
    int unsigned c;
    int unsigned diff;
    int unsigned area;
    int unsigned k;
    int unsigned lo;
    int unsigned hi;
    bit          last;
    new_cell_t   nc;
    side = side_eff();
    if (row_pos >= side || col_pos >= side) begin
      row_pos = 0;
      col_pos = 0;
    end
    r = row_pos;
    c = col_pos;
    line_rows[r % 4][c] = t;
    if (r == 0 && c == 0) begin
      base_temp = t;
      eq_run    = 1'b1;
    end
    diff = (t > base_temp) ? t - base_temp : base_temp - t;
    if (diff > tol_reg) eq_run = 1'b0;
    area = side * side;
    k    = r * side + c;
    last = (k == area - 1);
    if (k >= side + 1) begin
      lo = k - side - 1;
      hi = last ? k : lo;
    end else if (last) begin
      lo = 0;
      hi = k;
    end else begin
      lo = 1;
      hi = 0;
    end
    if (lo <= hi) begin
      for (int unsigned p = lo; p <= hi; p++) begin
        nc.temp = diffuse_cell(p / side, p % side, side);
        nc.last = (p == area - 1);
        nc.eq   = nc.last && eq_run;
        new_cell_q.push_back(nc);
      end
    end
    if (last) begin
      row_pos = 0;
      col_pos = 0;
    end else if (c + 1 >= side) begin
      col_pos = 0;
      row_pos = r + 1;
    end else begin
      col_pos = c + 1;
    end
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    errors++;
    $display("[%0t] result %0d: %s is %0h, expected %0h",
             $time, results_seen, what, got, want);
  endtask

  // -------------------------------------------------------------------------
  // Clock and reset
  // -------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // -------------------------------------------------------------------------
  // Driver: offers items from old_cell_q, holds each until accepted, and
  // inserts random gaps while tx_idle is set.
  // -------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      tx_gap      <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        step_grid(in_ch.cell_temperature);
        cells_taken++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (tx_gap > 0) begin
          tx_gap      <= tx_gap - 1;
          in_ch.valid <= 1'b0;
        end else if (old_cell_q.size() > 0) begin
          in_ch.valid            <= 1'b1;
          in_ch.cell_temperature <= old_cell_q.pop_front();
          if (tx_idle && $urandom_range(0, 5) == 0) tx_gap <= $urandom_range(1, 8);
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Long hold-off on the output, counted here so the sender keeps offering
  always @(posedge clk) begin
    if (!rst_n) hold_left <= 0;
    else if (hold_go) hold_left <= 200;
    else if (hold_left > 0) hold_left <= hold_left - 1;
  end

  // -------------------------------------------------------------------------
  // Monitor: checks every accepted result against the oldest prediction and
  // drives ready with random stall bursts.
  // -------------------------------------------------------------------------
  always @(posedge clk) begin
    new_cell_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      rx_gap       <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (new_cell_q.size() == 0) begin
          report_mismatch("unexpected item, temperature", out_ch.new_temperature, 0);
        end else begin
          want = new_cell_q.pop_front();
          if (out_ch.new_temperature !== want.temp)
            report_mismatch("new_temperature", out_ch.new_temperature, want.temp);
          if (out_ch.frame_last !== want.last)
            report_mismatch("frame_last", out_ch.frame_last, want.last);
          if (out_ch.at_equilibrium !== want.eq)
            report_mismatch("at_equilibrium", out_ch.at_equilibrium, want.eq);
          if (want.last) frames_seen++;
          if (want.eq) eq_frames++;
        end
        results_seen++;
      end
      if (hold_go || hold_left > 0) begin
        out_ch.ready <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap       <= rx_gap - 1;
        out_ch.ready <= 1'b0;
      end else if (rx_idle && $urandom_range(0, 7) == 0) begin
        rx_gap       <= $urandom_range(0, 7);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // -------------------------------------------------------------------------
  // Stimulus helpers
  // -------------------------------------------------------------------------
  task automatic write_cfg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we    <= 1'b0;
    // shadow follows the write; the block is idle so nothing is in flight
    case (idx)
      CfgGridSide: begin
        side_reg = data[SideW-1:0];
        restart_frame();
      end
      CfgGain: gain_reg = data;
      CfgTol:  tol_reg  = data;
      default: ;
    endcase
  endtask

  task automatic queue_cell(temp_t t);
    old_cell_q.push_back(t);
    cells_queued++;
  endtask

  // Sender pause: every item taken, every result out, then the drain
  task automatic wait_idle();
    while (cells_taken != cells_queued || new_cell_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  function automatic temp_t pick_cell(fill_t mode, temp_t base);
    int v;
    case (mode)
      FillNearFlat: begin
        v = int'(base) + int'($urandom_range(0, 6)) - 3;
        if (v < 0) v = 0;
        if (v > 65535) v = 65535;
        return temp_t'(v);
      end
      FillExtreme: begin
        case ($urandom_range(0, 2))
          0:       return '0;
          1:       return '1;
          default: return temp_t'($urandom);
        endcase
      end
      default: return temp_t'($urandom);
    endcase
  endfunction

  // -------------------------------------------------------------------------
  // Main sequence
  // -------------------------------------------------------------------------
  initial begin
    int unsigned      side;
    int               n_items;
    fill_t            mode;
    temp_t            base;
    logic [SideW-1:0] side_w;
    logic [CfgDataW-1:0] side_data;
    int               pick;

    rst_n                  = 1'b0;
    cfg_we                 = 1'b0;
    cfg_idx                = '0;
    cfg_wdata              = '0;
    hold_go                = 1'b0;
    in_ch.valid            = 1'b0;
    in_ch.cell_temperature = '0;
    out_ch.ready           = 1'b0;
    tx_idle                = 1'b1;
    rx_idle                = 1'b1;

    side_reg = SideRst;
    gain_reg = GainRst;
    tol_reg  = TolRst;
    foreach (line_rows[i, j]) line_rows[i][j] = '0;
    restart_frame();

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // ---- directed part ----
    // spare index takes all ones and must change nothing
    write_cfg(CfgSpare, '1);

    // one-cell grid keeps its value, at both ends of the range
    write_cfg(CfgGridSide, 16'd1);
    queue_cell('0);
    queue_cell('1);
    wait_idle();

    // side zero behaves as a one-cell grid
    write_cfg(CfgGridSide, 16'd0);
    queue_cell(16'd1234);
    wait_idle();

    // 2x2 with full gain: corners saturate high and clamp at zero
    write_cfg(CfgGridSide, 16'd2);
    write_cfg(CfgGain, '1);
    write_cfg(CfgTol, '0);
    queue_cell('0);
    queue_cell('1);
    queue_cell('1);
    queue_cell('0);
    wait_idle();

    // 3x3, zero gain: each cell passes through, widest tolerance
    write_cfg(CfgGridSide, 16'd3);
    write_cfg(CfgGain, '0);
    write_cfg(CfgTol, '1);
    for (int i = 0; i < 9; i++) queue_cell(pick_cell(FillExtreme, '0));
    wait_idle();

    // 3x3 flat field at half gain, zero tolerance: equilibrium holds
    write_cfg(CfgGain, 16'h8000);
    write_cfg(CfgTol, '0);
    base = temp_t'($urandom);
    for (int i = 0; i < 9; i++) queue_cell(base);
    wait_idle();

    // ---- random part ----
    while (cells_queued < RandomItems) begin
      phases++;
      // quiet channels for the closing stretch, otherwise mostly bursty
      if (cells_queued >= RandomItems - 70) begin
        tx_idle = 1'b0;
        rx_idle = 1'b0;
      end else begin
        tx_idle = ($urandom_range(0, 3) != 0);
        rx_idle = ($urandom_range(0, 3) != 0);
      end

      // register settings; some side writes also carry junk in the upper bits
      pick = $urandom_range(0, 5);
      if (pick == 0) write_cfg(CfgGain, '0);
      else if (pick == 1) write_cfg(CfgGain, '1);
      else if (pick == 2) write_cfg(CfgGain, GainRst);
      else if (pick == 3) write_cfg(CfgGain, CfgDataW'($urandom));
      pick = $urandom_range(0, 7);
      if (pick == 0) write_cfg(CfgTol, '0);
      else if (pick == 1) write_cfg(CfgTol, '1);
      else if (pick < 6) write_cfg(CfgTol, CfgDataW'($urandom_range(0, 64)));

      mode = fill_t'($urandom_range(0, 2));
      base = temp_t'($urandom);

      if (phases == 1) begin
        // output held off for a long stretch while 8x8 frames keep coming
        write_cfg(CfgGridSide, 16'd8);
        tx_idle = 1'b0;
        for (int i = 0; i < 128; i++) queue_cell(pick_cell(mode, base));
        @(posedge clk);
        hold_go <= 1'b1;
        @(posedge clk);
        hold_go <= 1'b0;
      end else if (phases == 2) begin
        // largest side, partial frame: reaches the last column and row wrap
        write_cfg(CfgGridSide, 16'd32);
        for (int i = 0; i < 70; i++) queue_cell(pick_cell(mode, base));
      end else if (phases == 3) begin
        // side above the maximum acts as the maximum
        write_cfg(CfgGridSide, 16'hFFFF);
        for (int i = 0; i < 40; i++) queue_cell(pick_cell(mode, base));
      end else begin
        if ($urandom_range(0, 4) != 0) begin
          pick = $urandom_range(0, 19);
          if (pick == 0) side_w = '0;
          else if (pick == 1) side_w = SideW'(1);
          else if (pick < 15) side_w = SideW'($urandom_range(2, 6));
          else if (pick < 19) side_w = SideW'($urandom_range(7, 10));
          else side_w = SideW'($urandom_range(11, 14));
          side_data = CfgDataW'(side_w);
          if ($urandom_range(0, 1) == 1)
            side_data = (CfgDataW'($urandom) & ~CfgDataW'(6'h3F)) | side_data;
          write_cfg(CfgGridSide, side_data);
        end
        side = side_eff();
        // mostly whole frames; sometimes a cut that leaves the frame open
        if (side > 16) n_items = $urandom_range(1, 40);
        else if ($urandom_range(0, 4) == 0) n_items = $urandom_range(1, side * side + side);
        else n_items = side * side * $urandom_range(1, 2);
        // stop at the quiet stretch and at the item target
        if (cells_queued < RandomItems - 70) begin
          if (n_items > RandomItems - 70 - cells_queued)
            n_items = RandomItems - 70 - cells_queued;
        end else if (n_items > RandomItems - cells_queued) begin
          n_items = RandomItems - cells_queued;
        end
        for (int i = 0; i < n_items; i++) queue_cell(pick_cell(mode, base));
      end
      wait_idle();
    end

    wait_idle();
    $display("Sent %0d items over %0d random phases, checked %0d results.",
             cells_queued, phases, results_seen);
    $display("Closed %0d frames, %0d of them at equilibrium; %0d mismatches.",
             frames_seen, eq_frames, errors);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Run limit, far beyond the slowest legal run
  initial begin
    #400000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
